@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the string extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pse_pkg.sv @@
// Types, constants and helper functions of the printable string extractor.
`timescale 1ns / 1ps

package pse_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_LENGTH  = 2'd0,
    REG_WIDE_ENABLE = 2'd1,
    REG_BIG_ENDIAN  = 2'd2,
    REG_RESULT_CAP  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0]  MinLengthReset = 8'd4;
  localparam logic [15:0] ResultCapReset = 16'd50000;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharFirst = 8'h20;
  localparam logic [7:0] CharLast  = 8'h7e;

  localparam logic KindString  = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [1:0] EncAscii   = 2'd0;
  localparam logic [1:0] EncUtf16Le = 2'd1;
  localparam logic [1:0] EncUtf16Be = 2'd2;

  // ASCII lane, wide lane 0, wide lane 1
  localparam int unsigned NumLanes = 3;
  // Byte-step closes (three lanes), end-of-image closes (three lanes), summary
  localparam int unsigned NumSlots    = 7;
  localparam int unsigned SlotSummary = 6;
  localparam int unsigned SlotIdxW    = 3;
  localparam int unsigned LaneIdxW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_image;
  } in_req_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] start_offset;
    logic [31:0] char_count;
    logic [1:0]  encoding;
    logic [31:0] total_count;
    logic        truncated;
    logic        last_result;
  } out_res_t;

  typedef struct packed {
    logic [31:0] start_offset;
    logic [31:0] char_count;
  } lane_rec_t;

  // One queue entry: every result that a single byte causes
  typedef struct packed {
    lane_rec_t [NumLanes-1:0] rec;
    logic [1:0]               wide_enc;
    logic [NumSlots-1:0]      slots;
    logic [31:0]              total_count;
    logic                     truncated;
  } entry_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b == CharTab) || ((b >= CharFirst) && (b <= CharLast));
  endfunction

endpackage

@@ rtl/core/pse_front.sv @@
// Front end: takes image bytes, tracks the three lanes and builds result entries.
`timescale 1ns / 1ps

module pse_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  pse_pkg::in_req_t                in_req_i,
  input  logic                            queue_full_i,
  output logic                            in_stall_o,
  output logic                            push_o,
  output pse_pkg::entry_t                 entry_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pse_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [pse_pkg::CfgDataW-1:0]    cfg_data_i
);

  `include "assert_macros.svh"

  typedef logic [OFFSET_BITS-1:0] pos_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic qualifies(input pos_t len, input logic [7:0] min_len);
    logic [7:0] need;
    need = (min_len == 8'd0) ? 8'd1 : min_len;
    return (len != '0) && (len >= pos_t'(need));
  endfunction

  function automatic logic [31:0] low32(input pos_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  // Configuration registers
  logic [7:0]  min_length_q;
  logic        wide_enable_q;
  logic        big_endian_q;
  logic [15:0] result_cap_q;

  // Scan state
  pos_t        pos_q, pos_d;
  pos_t        a_start_q, a_start_d;
  pos_t        a_len_q, a_len_d;
  pos_t        w_start_q [2];
  pos_t        w_start_d [2];
  pos_t        w_len_q [2];
  pos_t        w_len_d [2];
  logic [7:0]  w_first_q [2];
  logic [7:0]  w_first_d [2];
  logic [15:0] emitted_q, emitted_d;
  logic [31:0] found_q, found_d;
  logic        cap_hit_q, cap_hit_d;

  logic        accept;
  logic [7:0]  byte_w;
  logic        eoi;
  logic        pr;
  logic [7:0]  ch, zero;
  logic [1:0]  wenc;
  logic [pse_pkg::NumLanes-1:0]   close_b;
  logic [pse_pkg::NumLanes-1:0]   qual_e;
  logic [2*pse_pkg::NumLanes-1:0] qual;
  logic [2*pse_pkg::NumLanes-1:0] emit;
  pos_t        rec_start [pse_pkg::NumLanes];
  pos_t        rec_len [pse_pkg::NumLanes];
  logic [32:0] found_sum;
  logic [15:0] em;
  logic        hit;
  pse_pkg::entry_t entry;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = queue_full_i;
  assign cfg_ready_o = 1'b1;
  assign byte_w      = in_req_i.data_byte;
  assign eoi         = in_req_i.end_of_image;

  always_comb begin
    pos_d     = pos_q;
    a_start_d = a_start_q;
    a_len_d   = a_len_q;
    w_start_d = w_start_q;
    w_len_d   = w_len_q;
    w_first_d = w_first_q;
    close_b   = '0;
    ch        = '0;
    zero      = '0;
    pr        = pse_pkg::is_printable(byte_w);
    wenc      = big_endian_q ? pse_pkg::EncUtf16Be : pse_pkg::EncUtf16Le;

    // ASCII lane
    if (pr) begin
      if (a_len_q == '0) begin
        a_start_d = pos_q;
      end
      a_len_d = sat_inc(a_len_q);
    end else begin
      close_b[0] = 1'b1;
      a_len_d    = '0;
    end

    // Wide lanes: lane p pairs when the position parity differs from p
    for (int p = 0; p < 2; p++) begin
      if (pos_q[0] == 1'(p)) begin
        w_first_d[p] = byte_w;
      end else if (!wide_enable_q) begin
        w_len_d[p] = '0;
      end else if (pos_q >= pos_t'(p + 1)) begin
        ch   = big_endian_q ? byte_w : w_first_q[p];
        zero = big_endian_q ? w_first_q[p] : byte_w;
        if ((zero == 8'd0) && pse_pkg::is_printable(ch)) begin
          if (w_len_q[p] == '0) begin
            w_start_d[p] = pos_q - pos_t'(1);
          end
          w_len_d[p] = sat_inc(w_len_q[p]);
        end else begin
          close_b[p+1] = 1'b1;
          w_len_d[p]   = '0;
        end
      end
    end
    if (!wide_enable_q) begin
      w_len_d[0] = '0;
      w_len_d[1] = '0;
    end

    pos_d = sat_inc(pos_q);

    // A lane closes once per byte: either at the byte itself or at end of image
    rec_start[0] = close_b[0] ? a_start_q : a_start_d;
    rec_len[0]   = close_b[0] ? a_len_q : a_len_d;
    for (int p = 0; p < 2; p++) begin
      rec_start[p+1] = close_b[p+1] ? w_start_q[p] : w_start_d[p];
      rec_len[p+1]   = close_b[p+1] ? w_len_q[p] : w_len_d[p];
    end

    qual_e = '0;
    for (int l = 0; l < pse_pkg::NumLanes; l++) begin
      qual[l] = close_b[l] && qualifies(rec_len[l], min_length_q);
      qual_e[l] = eoi && !close_b[l] && qualifies(rec_len[l], min_length_q);
      qual[l+pse_pkg::NumLanes] = qual_e[l];
    end

    // Count every qualifying run, emit while below the cap
    found_sum = {1'b0, found_q} + 33'($countones(qual));
    found_d   = found_sum[32] ? 32'hffff_ffff : found_sum[31:0];
    em        = emitted_q;
    hit       = cap_hit_q;
    emit      = '0;
    for (int k = 0; k < 2 * pse_pkg::NumLanes; k++) begin
      if (qual[k]) begin
        if (em < result_cap_q) begin
          emit[k] = 1'b1;
          em      = em + 16'd1;
        end else begin
          hit = 1'b1;
        end
      end
    end
    emitted_d = em;
    cap_hit_d = hit;

    entry = '0;
    for (int l = 0; l < pse_pkg::NumLanes; l++) begin
      entry.rec[l].start_offset = low32(rec_start[l]);
      entry.rec[l].char_count   = low32(rec_len[l]);
    end
    entry.wide_enc    = wenc;
    entry.slots       = {eoi, emit};
    entry.total_count = found_d;
    entry.truncated   = cap_hit_d;

    // Return to the start-of-image state after the summary
    if (eoi) begin
      pos_d     = '0;
      a_start_d = '0;
      a_len_d   = '0;
      for (int p = 0; p < 2; p++) begin
        w_start_d[p] = '0;
        w_len_d[p]   = '0;
        w_first_d[p] = '0;
      end
      emitted_d = '0;
      found_d   = '0;
      cap_hit_d = 1'b0;
    end
  end

  assign push_o  = accept && (entry.slots != '0);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q  <= pse_pkg::MinLengthReset;
      wide_enable_q <= 1'b0;
      big_endian_q  <= 1'b0;
      result_cap_q  <= pse_pkg::ResultCapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pse_pkg::cfg_reg_e'(cfg_index_i))
        pse_pkg::REG_MIN_LENGTH:  min_length_q  <= cfg_data_i[7:0];
        pse_pkg::REG_WIDE_ENABLE: wide_enable_q <= cfg_data_i[0];
        pse_pkg::REG_BIG_ENDIAN:  big_endian_q  <= cfg_data_i[0];
        pse_pkg::REG_RESULT_CAP:  result_cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      a_start_q <= '0;
      a_len_q   <= '0;
      for (int p = 0; p < 2; p++) begin
        w_start_q[p] <= '0;
        w_len_q[p]   <= '0;
        w_first_q[p] <= '0;
      end
      emitted_q <= '0;
      found_q   <= '0;
      cap_hit_q <= 1'b0;
    end else if (accept) begin
      pos_q     <= pos_d;
      a_start_q <= a_start_d;
      a_len_q   <= a_len_d;
      w_start_q <= w_start_d;
      w_len_q   <= w_len_d;
      w_first_q <= w_first_d;
      emitted_q <= emitted_d;
      found_q   <= found_d;
      cap_hit_q <= cap_hit_d;
    end
  end

  `PSE_ASSERT_NXT(a_front_eoi_clears_pos, accept && eoi, pos_q == '0, "position not cleared after end of image")
  `PSE_ASSERT_IMP(a_front_eoi_pushes, accept && eoi, push_o, "end of image without a summary request")
  `PSE_ASSERT_IMP(a_front_no_push_when_full, queue_full_i, !push_o, "request pushed into a full queue")

endmodule

@@ rtl/core/pse_fifo.sv @@
// Short queue of result entries between the front end and the back end.
`timescale 1ns / 1ps

module pse_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pse_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pse_pkg::entry_t head_o
);

  `include "assert_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pse_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `PSE_ASSERT_IMP(a_fifo_no_overflow, push_i, !full_o, "push into a full queue")
  `PSE_ASSERT_IMP(a_fifo_no_underflow, pop_i, !empty_o, "pop from an empty queue")

endmodule

@@ rtl/core/pse_back.sv @@
// Back end: unpacks queued entries into result requests, one per cycle while not stalled.
`timescale 1ns / 1ps

module pse_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  pse_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pse_pkg::out_res_t out_res_o
);

  `include "assert_macros.svh"

  pse_pkg::entry_t cur_q, cur_d;
  logic [pse_pkg::NumSlots-1:0] slots_q, slots_d;
  logic [pse_pkg::NumSlots-1:0] remaining;
  logic [pse_pkg::SlotIdxW-1:0] pick;
  logic [pse_pkg::LaneIdxW-1:0] lane;
  logic fire;
  logic load;
  pse_pkg::out_res_t res;

  assign out_valid_o = (slots_q != '0);
  assign fire        = out_valid_o && !out_stall_i;

  always_comb begin
    pick = '0;
    for (int k = pse_pkg::NumSlots - 1; k >= 0; k--) begin
      if (slots_q[k]) begin
        pick = pse_pkg::SlotIdxW'(k);
      end
    end
    lane = (pick >= pse_pkg::SlotIdxW'(pse_pkg::NumLanes))
         ? pse_pkg::LaneIdxW'(pick - pse_pkg::SlotIdxW'(pse_pkg::NumLanes))
         : pse_pkg::LaneIdxW'(pick);
    remaining = slots_q & ~(pse_pkg::NumSlots'(1) << pick);

    res = '0;
    if (pick == pse_pkg::SlotIdxW'(pse_pkg::SlotSummary)) begin
      res.item_kind   = pse_pkg::KindSummary;
      res.total_count = cur_q.total_count;
      res.truncated   = cur_q.truncated;
    end else begin
      res.item_kind    = pse_pkg::KindString;
      res.start_offset = cur_q.rec[lane].start_offset;
      res.char_count   = cur_q.rec[lane].char_count;
      res.encoding     = (lane == '0) ? pse_pkg::EncAscii : cur_q.wide_enc;
    end
    res.last_result = (remaining == '0);
  end

  assign out_res_o = res;

  // Refill as the last request of an entry leaves, so entries run back to back
  assign load  = !out_valid_o || (fire && (remaining == '0));
  assign pop_o = load && !empty_i;

  always_comb begin
    cur_d   = cur_q;
    slots_d = slots_q;
    if (load) begin
      if (!empty_i) begin
        cur_d   = head_i;
        slots_d = head_i.slots;
      end else begin
        slots_d = '0;
      end
    end else if (fire) begin
      slots_d = remaining;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else begin
      slots_q <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  `PSE_ASSERT_IMP(a_back_summary_is_last, out_valid_o && (res.item_kind == pse_pkg::KindSummary), res.last_result, "summary request not marked last")
  `PSE_ASSERT_NXT(a_back_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(slots_q), "pending requests changed under stall")

endmodule

@@ rtl/core/printable_string_extractor_unit.sv @@
// Top level of the printable string extractor: front end, result queue, back end.
`timescale 1ns / 1ps

// Scans an image streamed one byte per request on in_req_i and reports runs of
// printable characters (tab or 0x20..0x7E) as ASCII and, with wide_enable set,
// as UTF-16 at both pair parities. The front end takes one byte every cycle and
// does all lane tracking, counting and cap handling for it in that cycle, so a
// byte is accepted per clock as long as the result queue (QUEUE_DEPTH entries)
// has room. Each byte that causes results places one entry in the queue; the
// back end sends those results out at one per cycle while out_stall_i is low,
// up to four for an end of image byte (runs first, then the summary with
// last_result set). The output rate is thus the limit: bytes that each cause at
// most one result stream at one per cycle without output stalls, while bursts
// of closing runs fill the queue and stall the input. The first result of a
// byte reaches out_res_o once its entry is in the queue and loaded into the
// back end. There is no clearing pass after reset. Configuration writes are
// taken every cycle and must only occur while no byte is in flight.
module printable_string_extractor_unit #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pse_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pse_pkg::out_res_t             out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pse_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pse_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  pse_pkg::entry_t push_entry;
  pse_pkg::entry_t head_entry;

  pse_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .queue_full_i(full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .entry_o     (push_entry),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pse_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head_entry)
  );

  pse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule
